// File: rtl/rdpd_pkg.sv
// shared constants and types of the ray depth to planar depth converter
package rdpd_pkg;
   localparam int MAX_IMAGE_DIM_DEF = 4096;
   localparam int DEPTH_BITS_DEF    = 24;
   localparam int COORD_W           = 12;
   localparam int DIM_W             = 13;
   localparam int FOCAL_W           = 20;
   localparam int SQ_W              = 2 * FOCAL_W;
   localparam int OFS_W             = 16;
   localparam int SUM_W             = 48;
   localparam int CSR_IDX_W         = 2;
   localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [FOCAL_W-1:0] FOCAL_RESET = 20'd128000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FOCAL  = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic valid;
      logic zero;
   } ctl_type;
endpackage

// File: rtl/rdpd_front.sv
// front stages: offsets, squares, sum of squares and squared numerator
module rdpd_front #(
   parameter int DEPTH_BITS = rdpd_pkg::DEPTH_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [DEPTH_BITS-1:0]               depth,
   input  logic [rdpd_pkg::COORD_W-1:0]        col,
   input  logic [rdpd_pkg::COORD_W-1:0]        row,
   input  logic [rdpd_pkg::FOCAL_W-1:0]        focal,
   input  logic [rdpd_pkg::DIM_W-1:0]          width,
   input  logic [rdpd_pkg::DIM_W-1:0]          height,
   output rdpd_pkg::ctl_type                   ctl_out,
   output logic [rdpd_pkg::SUM_W-1:0]          s_out,
   output logic [2*DEPTH_BITS+rdpd_pkg::SUM_W+2:0] t_out,
   output logic [2*DEPTH_BITS+rdpd_pkg::SUM_W+2:0] p_out,
   output logic [2*DEPTH_BITS+rdpd_pkg::SUM_W+2:0] q_out
);
   import rdpd_pkg::*;
   localparam int DW = DEPTH_BITS;
   localparam int WW = 2 * DW + SUM_W + 3;

   ctl_type c1_ff, c2_ff, c3_ff, c4_ff;
   ctl_type c1_in;
   logic [DW-1:0] d1_ff;
   logic [FOCAL_W-1:0] f1_ff;
   logic signed [OFS_W-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic [2*DW-1:0] d2_ff;
   logic [SQ_W-1:0] f2_ff;
   logic [2*OFS_W-1:0] xsq_ff, ysq_ff;
   logic [DW+SQ_W-1:0] pl_ff, ph_ff;
   logic [SUM_W-1:0] s3_ff, s4_ff, s3_in;
   logic [WW-1:0] t4_ff, p4_ff, q4_ff, t4_in;

   // half-pixel offsets from the optical centre
   assign dx_in = $signed({3'b000, col, 1'b0}) - $signed({3'b000, width}) + 16'sd1;
   assign dy_in = $signed({3'b000, row, 1'b0}) - $signed({3'b000, height}) + 16'sd1;
   assign c1_in = '{valid: start, zero: (focal == '0)};
   assign s3_in = SUM_W'(f2_ff) + SUM_W'({({1'b0, xsq_ff} + {1'b0, ysq_ff}), 14'b0});
   assign t4_in = WW'({(WW'(ph_ff) << DW) + WW'(pl_ff), 2'b00});

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
         c3_ff <= '0;
         c4_ff <= '0;
      end else begin
         c1_ff <= c1_in;
         c2_ff <= c1_ff;
         c3_ff <= c2_ff;
         c4_ff <= c3_ff;
      end
   end

   always_ff @(posedge clock) begin
      d1_ff  <= depth;
      f1_ff  <= focal;
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      d2_ff  <= d1_ff * d1_ff;
      f2_ff  <= f1_ff * f1_ff;
      xsq_ff <= (2*OFS_W)'(dx_ff * dx_ff);
      ysq_ff <= (2*OFS_W)'(dy_ff * dy_ff);
      pl_ff  <= d2_ff[DW-1:0] * f2_ff;
      ph_ff  <= d2_ff[2*DW-1:DW] * f2_ff;
      s3_ff  <= s3_in;
      s4_ff  <= s3_ff;
      t4_ff  <= t4_in;
      p4_ff  <= WW'(s3_ff);
      q4_ff  <= WW'(0) - WW'(s3_ff);
   end

   assign ctl_out = c4_ff;
   assign s_out   = s4_ff;
   assign t_out   = t4_ff;
   assign p_out   = p4_ff;
   assign q_out   = q4_ff;
endmodule

// File: rtl/rdpd_bit.sv
// one result bit of the rounded quotient search, shift and add only
module rdpd_bit #(
   parameter int DEPTH_BITS = rdpd_pkg::DEPTH_BITS_DEF,
   parameter int BIT        = 0
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  rdpd_pkg::ctl_type                       ctl_in,
   input  logic [DEPTH_BITS-1:0]                   z_in,
   input  logic [rdpd_pkg::SUM_W-1:0]              s_in,
   input  logic [2*DEPTH_BITS+rdpd_pkg::SUM_W+2:0] t_in,
   input  logic [2*DEPTH_BITS+rdpd_pkg::SUM_W+2:0] p_in,
   input  logic [2*DEPTH_BITS+rdpd_pkg::SUM_W+2:0] q_in,
   output rdpd_pkg::ctl_type                       ctl_out,
   output logic [DEPTH_BITS-1:0]                   z_out,
   output logic [rdpd_pkg::SUM_W-1:0]              s_out,
   output logic [2*DEPTH_BITS+rdpd_pkg::SUM_W+2:0] t_out,
   output logic [2*DEPTH_BITS+rdpd_pkg::SUM_W+2:0] p_out,
   output logic [2*DEPTH_BITS+rdpd_pkg::SUM_W+2:0] q_out
);
   import rdpd_pkg::*;
   localparam int WW = 2 * DEPTH_BITS + SUM_W + 3;

   ctl_type ctl_ff;
   logic [DEPTH_BITS-1:0] z_ff, z_in2;
   logic [SUM_W-1:0] s_ff;
   logic [WW-1:0] t_ff, p_ff, q_ff, trial, p_nx, q_nx;
   logic take;

   // p holds (2z-1)^2*s, q holds (2z-1)*s, modulo 2^WW
   assign trial = p_in + (q_in << (BIT + 2)) + (WW'(s_in) << (2 * BIT + 2));
   assign take  = (trial <= t_in);
   assign p_nx  = take ? trial : p_in;
   assign q_nx  = take ? q_in + (WW'(s_in) << (BIT + 1)) : q_in;
   assign z_in2 = take ? (z_in | (DEPTH_BITS'(1) << BIT)) : z_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      z_ff <= z_in2;
      s_ff <= s_in;
      t_ff <= t_in;
      p_ff <= p_nx;
      q_ff <= q_nx;
   end

   assign ctl_out = ctl_ff;
   assign z_out   = z_ff;
   assign s_out   = s_ff;
   assign t_out   = t_ff;
   assign p_out   = p_ff;
   assign q_out   = q_ff;
endmodule

// File: rtl/ray_depth_to_planar_depth.sv
// top level of the ray depth to planar depth converter
//
//  channel  ports                              handshake
//  request  req_ray_depth/col/row              start high, busy low
//  response rsp_planar_depth                   rsp_valid for one cycle
//  csr      csr_index, csr_data                csr_valid and csr_ready
//
// one word enters per cycle; its result appears after the four front stages (offsets,
// squares, partial products, squared numerator) and one pipeline stage per result bit
// of the rounding search
// busy stays low and csr_ready high; the receiver cannot stall, so nothing holds
// synchronous reset clears all valid bits and loads the register defaults
module ray_depth_to_planar_depth #(
   parameter int MAX_IMAGE_DIM = rdpd_pkg::MAX_IMAGE_DIM_DEF,
   parameter int DEPTH_BITS    = rdpd_pkg::DEPTH_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [DEPTH_BITS-1:0]            req_ray_depth,
   input  logic [rdpd_pkg::COORD_W-1:0]     req_pixel_col,
   input  logic [rdpd_pkg::COORD_W-1:0]     req_pixel_row,
   output logic                             rsp_valid,
   output logic [DEPTH_BITS-1:0]            rsp_planar_depth,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rdpd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rdpd_pkg::FOCAL_W-1:0]     csr_data
);
   import rdpd_pkg::*;
   localparam int DW = DEPTH_BITS;
   localparam int WW = 2 * DW + SUM_W + 3;
   localparam int MAX_W = 16;

   logic [FOCAL_W-1:0] focal_ff;
   logic [DIM_W-1:0] width_ff, height_ff, dim_sat;
   logic [MAX_W-1:0] max_dim;

   ctl_type ctl_c [0:DW];
   logic [DW-1:0] z_c [0:DW];
   logic [SUM_W-1:0] s_c [0:DW];
   logic [WW-1:0] t_c [0:DW];
   logic [WW-1:0] p_c [0:DW];
   logic [WW-1:0] q_c [0:DW];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // dimension writes saturate at the largest supported image size
   assign max_dim = MAX_W'(MAX_IMAGE_DIM);
   assign dim_sat = ({3'b000, csr_data[DIM_W-1:0]} > max_dim) ? DIM_W'(max_dim)
                                                               : csr_data[DIM_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff  <= FOCAL_RESET;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FOCAL:  focal_ff  <= csr_data;
            CSR_WIDTH:  width_ff  <= dim_sat;
            CSR_HEIGHT: height_ff <= dim_sat;
            default: ;
         endcase
      end
   end

   // geometry and squared terms
   rdpd_front #(.DEPTH_BITS(DW)) u_front (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .depth   (req_ray_depth),
      .col     (req_pixel_col),
      .row     (req_pixel_row),
      .focal   (focal_ff),
      .width   (width_ff),
      .height  (height_ff),
      .ctl_out (ctl_c[0]),
      .s_out   (s_c[0]),
      .t_out   (t_c[0]),
      .p_out   (p_c[0]),
      .q_out   (q_c[0])
   );
   assign z_c[0] = '0;

   // result bits from the top down, one stage each
   for (genvar j = 0; j < DW; j++) begin : g_bit
      rdpd_bit #(.DEPTH_BITS(DW), .BIT(DW - 1 - j)) u_bit (
         .clock   (clock),
         .reset   (reset),
         .ctl_in  (ctl_c[j]),
         .z_in    (z_c[j]),
         .s_in    (s_c[j]),
         .t_in    (t_c[j]),
         .p_in    (p_c[j]),
         .q_in    (q_c[j]),
         .ctl_out (ctl_c[j+1]),
         .z_out   (z_c[j+1]),
         .s_out   (s_c[j+1]),
         .t_out   (t_c[j+1]),
         .p_out   (p_c[j+1]),
         .q_out   (q_c[j+1])
      );
   end

   // zero focal length forces a zero result
   assign rsp_valid        = ctl_c[DW].valid;
   assign rsp_planar_depth = ctl_c[DW].zero ? '0 : z_c[DW];
endmodule

// File: rtl/rdpd_checker.sv
// port-level checks of the converter and their binding
module rdpd_checker #(
   parameter int DEPTH_BITS = rdpd_pkg::DEPTH_BITS_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic [DEPTH_BITS-1:0] req_ray_depth,
   input logic                  rsp_valid,
   input logic [DEPTH_BITS-1:0] rsp_planar_depth,
   input logic                  csr_ready
);
   localparam int LAT = DEPTH_BITS + 4;

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy && csr_ready)
      else $error("busy or csr_ready stuck");
   a_resp_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without request");
   a_not_deeper: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_planar_depth <= $past(req_ray_depth, LAT))
      else $error("planar depth exceeds ray depth");
   a_zero_depth: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_ray_depth, LAT) == '0) |-> rsp_planar_depth == '0)
      else $error("zero depth gives nonzero result");
endmodule

bind ray_depth_to_planar_depth rdpd_checker #(.DEPTH_BITS(DEPTH_BITS)) u_rdpd_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_ray_depth    (req_ray_depth),
   .rsp_valid        (rsp_valid),
   .rsp_planar_depth (rsp_planar_depth),
   .csr_ready        (csr_ready)
);

// File: tb/ray_depth_to_planar_depth_test.sv
// self-checking testbench of the ray depth to planar depth converter
module ray_depth_to_planar_depth_test;
   timeunit 1ns;
   timeprecision 1ps;
   import rdpd_pkg::*;

   localparam int DW = DEPTH_BITS_DEF;
   // index with no register behind it, writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int LATENCY = DW + 4;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [DW-1:0] DEPTH_MAX = '1;
   localparam logic [FOCAL_W-1:0] FOCAL_MAX = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [DW-1:0] req_ray_depth = '0;
   logic [COORD_W-1:0] req_pixel_col = '0;
   logic [COORD_W-1:0] req_pixel_row = '0;
   logic rsp_valid;
   logic [DW-1:0] rsp_planar_depth;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [FOCAL_W-1:0] csr_data = '0;

   ray_depth_to_planar_depth u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // own copy of the registers, updated when a csr word is taken
   logic [FOCAL_W-1:0] focal_q = FOCAL_RESET;
   logic [DIM_W-1:0] width_q = WIDTH_RESET;
   logic [DIM_W-1:0] height_q = HEIGHT_RESET;

   logic [DW-1:0] planar_queue[$];
   int failures = 0;
   int cycles = 0;

   function automatic logic [DIM_W-1:0] clamp_dim(logic [FOCAL_W-1:0] v);
      logic [DIM_W-1:0] d;
      d = v[DIM_W-1:0];
      return (d > DIM_W'(MAX_IMAGE_DIM_DEF)) ? DIM_W'(MAX_IMAGE_DIM_DEF) : d;
   endfunction

   // z = D*F / sqrt(F^2 + 16384*(dx2^2 + dy2^2)), nearest, ties up:
   // the largest q in [0, D] with (2q-1)^2 * s <= (2*D*F)^2
   function automatic logic [DW-1:0] planar_of(logic [DW-1:0] d, logic [COORD_W-1:0] c,
                                               logic [COORD_W-1:0] r);
      longint dx2, dy2, r2;
      logic [127:0] s, tgt, lhs, a;
      logic [DW:0] lo, hi, mid;
      if (focal_q == 0) return '0;
      dx2 = 2 * longint'(c) - (longint'(width_q) - 1);
      dy2 = 2 * longint'(r) - (longint'(height_q) - 1);
      r2 = dx2 * dx2 + dy2 * dy2;
      s = 128'(focal_q) * 128'(focal_q) + 128'(r2) * 128'd16384;
      tgt = 128'(d) * 128'(focal_q) * 128'd2;
      tgt = tgt * tgt;
      lo = '0;
      hi = (DW+1)'(d);
      while (lo < hi) begin
         mid = (DW+1)'(lo + (hi - lo + 1) / 2);
         a = 128'(mid) * 2 - 1;
         lhs = a * a * s;
         if (lhs <= tgt) lo = mid;
         else hi = (DW+1)'(mid - 1);
      end
      return lo[DW-1:0];
   endfunction

   // scoreboard: queue on acceptance, compare each strobed word
   always @(posedge clock) begin
      logic [DW-1:0] want;
      cycles <= cycles + 1;
      if (!reset) begin
         if (rsp_valid) begin
            if (planar_queue.size() == 0) begin
               $display("%0t unexpected word: expected none, actual %0d", $time,
                        rsp_planar_depth);
               failures++;
            end else begin
               want = planar_queue.pop_front();
               if (rsp_planar_depth !== want) begin
                  $display("%0t planar_depth: expected %0d, actual %0d", $time, want,
                           rsp_planar_depth);
                  failures++;
               end
            end
         end
         if (start && !busy)
            planar_queue.push_back(planar_of(req_ray_depth, req_pixel_col, req_pixel_row));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FOCAL: focal_q <= csr_data;
               CSR_WIDTH: width_q <= clamp_dim(csr_data);
               CSR_HEIGHT: height_q <= clamp_dim(csr_data);
               default: ;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // wait for every pending word, then let the pipe drain
   task automatic settle();
      while (planar_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [FOCAL_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(logic [FOCAL_W-1:0] f, logic [FOCAL_W-1:0] w,
                             logic [FOCAL_W-1:0] h);
      settle();
      csr_write(CSR_FOCAL, f);
      csr_write(CSR_WIDTH, w);
      csr_write(CSR_HEIGHT, h);
   endtask

   // presents one word and holds it until taken; start is left high
   task automatic send_word(logic [DW-1:0] d, logic [COORD_W-1:0] c, logic [COORD_W-1:0] r);
      start <= 1'b1;
      req_ray_depth <= d;
      req_pixel_col <= c;
      req_pixel_row <= r;
      do @(posedge clock); while (busy);
   endtask

   typedef struct {
      bit new_cfg;
      logic [FOCAL_W-1:0] f, w, h;
      logic [DW-1:0] d;
      logic [COORD_W-1:0] c, r;
      bit has_want;
      logic [DW-1:0] want;
   } row_t;

   // directed rows; the wanted value is filled in only where it is obvious
   row_t rows[] = '{
      // reset settings: zero depth, extremes of depth and position
      '{0, 0, 0, 0, 0, 0, 0, 1, 0},
      '{0, 0, 0, 0, DEPTH_MAX, 0, 0, 0, 0},
      '{0, 0, 0, 0, DEPTH_MAX, 4095, 4095, 0, 0},
      '{0, 0, 0, 0, 1, 320, 240, 0, 0},
      '{0, 0, 0, 0, 24'h800001, 2048, 1, 0, 0},
      // one-pixel image: the pixel sits on the axis, so depth passes through
      '{1, FOCAL_RESET, 1, 1, DEPTH_MAX, 0, 0, 1, DEPTH_MAX},
      '{0, 0, 0, 0, 12345, 0, 0, 1, 12345},
      // pixel outside the image
      '{0, 0, 0, 0, DEPTH_MAX, 4095, 0, 0, 0},
      // zero focal length gives zero
      '{1, 0, 640, 480, DEPTH_MAX, 4095, 4095, 1, 0},
      '{0, 0, 0, 0, 1, 0, 0, 1, 0},
      // smallest focal length, largest image
      '{1, 1, 4096, 4096, DEPTH_MAX, 0, 0, 0, 0},
      '{0, 0, 0, 0, DEPTH_MAX, 2047, 2048, 0, 0},
      // largest focal length, oversize dimensions saturate
      '{1, FOCAL_MAX, 8191, 4097, DEPTH_MAX, 4095, 4095, 0, 0},
      '{0, 0, 0, 0, DEPTH_MAX, 2047, 2047, 0, 0},
      // zero dimensions put the centre at minus one half
      '{1, 256, 0, 0, DEPTH_MAX, 0, 0, 0, 0},
      '{0, 0, 0, 0, DEPTH_MAX, 4095, 4095, 0, 0},
      '{0, 0, 0, 0, 24'h5a5a5a, 1365, 2730, 0, 0}
   };

   function automatic logic [DW-1:0] rand_depth();
      case ($urandom_range(0, 5))
         0: return DW'($urandom_range(0, 255));
         1: return DEPTH_MAX - DW'($urandom_range(0, 255));
         default: return DW'($urandom);
      endcase
   endfunction

   function automatic logic [DIM_W-1:0] rand_dim();
      case ($urandom_range(0, 7))
         0: return DIM_W'(1);
         1: return DIM_W'(4096);
         2: return DIM_W'($urandom_range(4097, 8191));
         3: return DIM_W'(0);
         default: return DIM_W'($urandom_range(1, 4096));
      endcase
   endfunction

   initial begin
      logic [FOCAL_W-1:0] f;
      logic [FOCAL_W-1:0] w, h;
      int burst, left;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // a write to the spare index must leave the settings alone
      csr_write(CSR_SPARE, FOCAL_W'($urandom));

      foreach (rows[i]) begin
         if (rows[i].new_cfg) begin
            start <= 1'b0;
            set_config(rows[i].f, rows[i].w, rows[i].h);
         end
         send_word(rows[i].d, rows[i].c, rows[i].r);
         if (rows[i].has_want && planar_of(rows[i].d, rows[i].c, rows[i].r) !== rows[i].want) begin
            $display("%0t directed row %0d: expected %0d, actual predicted %0d", $time, i,
                     rows[i].want, planar_of(rows[i].d, rows[i].c, rows[i].r));
            failures++;
         end
      end
      start <= 1'b0;

      // random part: phases of reset, extreme and random settings, bursty sender
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: f = FOCAL_RESET;
            1: f = FOCAL_MAX;
            2: f = FOCAL_W'(1);
            3: f = FOCAL_W'(0);
            default: f = FOCAL_W'($urandom_range(1, 2 ** FOCAL_W - 1));
         endcase
         w = (phase == 0) ? FOCAL_W'(WIDTH_RESET) : FOCAL_W'(rand_dim());
         h = (phase == 0) ? FOCAL_W'(HEIGHT_RESET) : FOCAL_W'(rand_dim());
         set_config(f, w, h);
         left = 250;
         while (left > 0) begin
            burst = $urandom_range(1, 24);
            if (burst > left) burst = left;
            for (int k = 0; k < burst; k++)
               send_word(rand_depth(), COORD_W'($urandom), COORD_W'($urandom));
            left -= burst;
            // random gap, sometimes none so bursts run back to back
            if ($urandom_range(0, 3) != 0) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end
         end
         start <= 1'b0;
      end

      settle();
      if (failures == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule
